[rtl/glyph_column_stream_generator_defines.svh]
// Assertion helpers for the glyph column stream generator.
`ifndef GLYPH_COLUMN_STREAM_GENERATOR_DEFINES_SVH
`define GLYPH_COLUMN_STREAM_GENERATOR_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define GCSG_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define GCSG_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/gcsg_pkg.sv]
package gcsg_pkg;

  localparam int GLYPH_COLUMNS = 6;
  localparam int GLYPH_COUNT   = 17;

  localparam logic       FUNC_SMALL = 1'b0;
  localparam logic       FUNC_BIG   = 1'b1;

  localparam logic [1:0] POS_HUNDREDS = 2'd0;
  localparam logic [1:0] POS_TENS     = 2'd1;
  localparam logic [1:0] POS_UNITS    = 2'd2;

  localparam logic [2:0] REP_MIN   = 3'd1;
  localparam logic [2:0] REP_MAX   = 3'd4;
  localparam logic [2:0] REP_RESET = 3'd3;

  localparam logic [7:0] CMD_COL_HI = 8'h10;
  localparam logic [7:0] CMD_PAGE   = 8'hB0;

  // Reciprocal constants: n/100 = (n*41)>>12 and n/10 = (n*205)>>11, exact below 1024
  localparam int RECIP100 = 41;
  localparam int SHIFT100 = 12;
  localparam int RECIP10  = 205;
  localparam int SHIFT10  = 11;

  localparam logic [7:0] FONT [GLYPH_COUNT][GLYPH_COLUMNS] = '{
    '{8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E, 8'h00},
    '{8'h00, 8'h42, 8'h7F, 8'h40, 8'h00, 8'h00},
    '{8'h72, 8'h49, 8'h49, 8'h49, 8'h46, 8'h00},
    '{8'h21, 8'h41, 8'h49, 8'h4D, 8'h33, 8'h00},
    '{8'h18, 8'h14, 8'h12, 8'h7F, 8'h10, 8'h00},
    '{8'h27, 8'h45, 8'h45, 8'h45, 8'h39, 8'h00},
    '{8'h3C, 8'h4A, 8'h49, 8'h49, 8'h31, 8'h00},
    '{8'h41, 8'h21, 8'h11, 8'h09, 8'h07, 8'h00},
    '{8'h36, 8'h49, 8'h49, 8'h49, 8'h36, 8'h00},
    '{8'h46, 8'h49, 8'h49, 8'h29, 8'h1E, 8'h00},
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'hC6, 8'h66, 8'h30, 8'h18, 8'hCC, 8'hC4},
    '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h22, 8'h00},
    '{8'h7F, 8'h04, 8'h04, 8'h04, 8'h78, 8'h00},
    '{8'h00, 8'h08, 8'h1C, 8'h1C, 8'h3E, 8'h7F},
    '{8'h1C, 8'h1C, 8'h1C, 8'h1C, 8'h1C, 8'h1C},
    '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  // Request held between the input register and the sequencer
  typedef struct packed {
    logic       func;
    logic [4:0] glyph;
    logic [9:0] quot;   // number divided by the digit's place value
    logic [6:0] start;  // wrapped start column
    logic [3:0] page;
    logic [2:0] rep;    // columns per stretched column, 1 in small mode
  } gcsg_item_t;

  function automatic logic [7:0] font_col(input logic [4:0] idx, input logic [2:0] c);
    logic [7:0] r;
    r = 8'h00;
    if (32'(idx) < GLYPH_COUNT && 32'(c) < GLYPH_COLUMNS) begin
      r = FONT[idx][c];
    end
    return r;
  endfunction

  // abcdefgh -> aabbccddeeffgghh
  function automatic logic [15:0] bit_double(input logic [7:0] x);
    logic [15:0] r;
    for (int i = 0; i < 8; i++) begin
      r[2*i]   = x[i];
      r[2*i+1] = x[i];
    end
    return r;
  endfunction

endpackage

[rtl/gcsg_front.sv]
module gcsg_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                in_func,
  input  logic [4:0]          in_glyph,
  input  logic [9:0]          in_number,
  input  logic [1:0]          in_digit_pos,
  input  logic [6:0]          in_col,
  input  logic [3:0]          in_page,
  input  logic [2:0]          rep_cfg,
  input  logic                take,
  output logic                busy,
  output logic                pend_valid,
  output gcsg_pkg::gcsg_item_t pend
);
  import gcsg_pkg::*;

  logic        pend_valid_r, pend_valid_nxt;
  gcsg_item_t  pend_r, pend_nxt;
  logic        accept;
  logic [2:0]  rep_eff;
  logic [1:0]  pos_eff;
  logic [6:0]  offset;
  logic [15:0] prod100;
  logic [17:0] prod10;

  assign busy   = pend_valid_r && !take;
  assign accept = start && !busy;

  always_comb begin
    rep_eff = rep_cfg;
    if (rep_cfg < REP_MIN) begin
      rep_eff = REP_MIN;
    end else if (rep_cfg > REP_MAX) begin
      rep_eff = REP_MAX;
    end
    pos_eff = (in_digit_pos > POS_UNITS) ? POS_UNITS : in_digit_pos;
    offset  = 7'(pos_eff) * 7'(rep_eff) * 7'(GLYPH_COLUMNS);
    prod100 = 16'(in_number) * 16'(RECIP100);
    prod10  = 18'(in_number) * 18'(RECIP10);

    pend_nxt.func  = in_func;
    pend_nxt.glyph = in_glyph;
    pend_nxt.page  = in_page;
    case (pos_eff)
      POS_HUNDREDS: pend_nxt.quot = 10'(prod100 >> SHIFT100);
      POS_TENS:     pend_nxt.quot = 10'(prod10 >> SHIFT10);
      default:      pend_nxt.quot = in_number;
    endcase
    if (in_func == FUNC_BIG) begin
      pend_nxt.start = 7'(in_col + offset);
      pend_nxt.rep   = rep_eff;
    end else begin
      pend_nxt.start = in_col;
      pend_nxt.rep   = REP_MIN;
    end

    pend_valid_nxt = pend_valid_r;
    if (accept) begin
      pend_valid_nxt = 1'b1;
    end else if (take) begin
      pend_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else begin
      pend_valid_r <= pend_valid_nxt;
    end
    if (accept) begin
      pend_r <= pend_nxt;
    end
  end

  assign pend_valid = pend_valid_r;
  assign pend       = pend_r;

endmodule

[rtl/gcsg_seq.sv]
module gcsg_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 pend_valid,
  input  gcsg_pkg::gcsg_item_t pend,
  output logic                 take,
  output logic                 out_strobe,
  output logic [7:0]           out_byte,
  output logic                 out_is_command,
  output logic                 out_starts_transfer,
  output logic                 out_last
);
  import gcsg_pkg::*;

  typedef enum logic [1:0] {ST_COL_LO, ST_COL_HI, ST_PAGE, ST_DATA} step_t;

  step_t       step_r, step_nxt;
  logic        act_valid_r, act_valid_nxt;
  logic        half_r, half_nxt;
  logic [2:0]  col_r, col_nxt;
  logic [1:0]  rep_cnt_r, rep_cnt_nxt;
  logic        big_r, big_nxt;
  logic [4:0]  font_idx_r, font_idx_nxt;
  logic [6:0]  start_r, start_nxt;
  logic [3:0]  page_r, page_nxt;
  logic [2:0]  rep_r, rep_nxt;
  logic        strobe_r, strobe_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic        cmd_r, cmd_nxt;
  logic        first_r, first_nxt;
  logic        last_r, last_nxt;

  logic        rep_last, col_last, item_end;
  logic [7:0]  font_byte;
  logic [15:0] dbl;
  logic [17:0] qprod;
  logic [6:0]  q10;
  logic [9:0]  q10x;
  logic [3:0]  digit;
  logic [3:0]  cur_page;

  always_comb begin
    rep_last  = (rep_cnt_r == 2'(rep_r - 3'd1));
    col_last  = (col_r == 3'(GLYPH_COLUMNS - 1));
    font_byte = font_col(font_idx_r, col_r);
    dbl       = bit_double(font_byte);
    cur_page  = half_r ? 4'(page_r + 4'd1) : page_r;
    item_end  = act_valid_r && (step_r == ST_DATA) && col_last && rep_last
                && (!big_r || half_r);
    take      = pend_valid && (!act_valid_r || item_end);

    // last decimal digit of the quotient: q - 10*(q/10)
    qprod = 18'(pend.quot) * 18'(RECIP10);
    q10   = 7'(qprod >> SHIFT10);
    q10x  = {q10, 3'b000} + {2'b00, q10, 1'b0};
    digit = 4'(pend.quot - q10x);

    byte_nxt  = 8'h00;
    cmd_nxt   = 1'b0;
    first_nxt = 1'b0;
    case (step_r)
      ST_COL_LO: begin
        byte_nxt  = {4'b0000, start_r[3:0]};
        cmd_nxt   = 1'b1;
        first_nxt = 1'b1;
      end
      ST_COL_HI: begin
        byte_nxt = CMD_COL_HI | {5'b00000, start_r[6:4]};
        cmd_nxt  = 1'b1;
      end
      ST_PAGE: begin
        byte_nxt = CMD_PAGE | {4'b0000, cur_page};
        cmd_nxt  = 1'b1;
      end
      ST_DATA: begin
        if (!big_r) begin
          byte_nxt = font_byte;
        end else begin
          byte_nxt = half_r ? dbl[15:8] : dbl[7:0];
        end
        first_nxt = (col_r == 3'd0) && (rep_cnt_r == 2'd0);
      end
      default: begin
        byte_nxt = 8'h00;
      end
    endcase
    strobe_nxt = act_valid_r;
    last_nxt   = item_end;

    act_valid_nxt = act_valid_r;
    step_nxt      = step_r;
    half_nxt      = half_r;
    col_nxt       = col_r;
    rep_cnt_nxt   = rep_cnt_r;
    big_nxt       = big_r;
    font_idx_nxt  = font_idx_r;
    start_nxt     = start_r;
    page_nxt      = page_r;
    rep_nxt       = rep_r;

    if (act_valid_r) begin
      case (step_r)
        ST_COL_LO: step_nxt = ST_COL_HI;
        ST_COL_HI: step_nxt = ST_PAGE;
        ST_PAGE: begin
          step_nxt    = ST_DATA;
          col_nxt     = 3'd0;
          rep_cnt_nxt = 2'd0;
        end
        ST_DATA: begin
          if (rep_last) begin
            rep_cnt_nxt = 2'd0;
            if (col_last) begin
              // last column done: after the low half, cursor to the next page
              col_nxt  = 3'd0;
              half_nxt = 1'b1;
              step_nxt = ST_COL_LO;
            end else begin
              col_nxt = col_r + 3'd1;
            end
          end else begin
            rep_cnt_nxt = rep_cnt_r + 2'd1;
          end
        end
        default: step_nxt = ST_COL_LO;
      endcase
    end

    if (item_end) begin
      act_valid_nxt = 1'b0;
    end

    if (take) begin
      act_valid_nxt = 1'b1;
      step_nxt      = ST_COL_LO;
      half_nxt      = 1'b0;
      col_nxt       = 3'd0;
      rep_cnt_nxt   = 2'd0;
      big_nxt       = (pend.func == FUNC_BIG);
      font_idx_nxt  = (pend.func == FUNC_BIG) ? {1'b0, digit} : pend.glyph;
      start_nxt     = pend.start;
      page_nxt      = pend.page;
      rep_nxt       = pend.rep;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_valid_r <= 1'b0;
      step_r      <= ST_COL_LO;
      half_r      <= 1'b0;
      col_r       <= 3'd0;
      rep_cnt_r   <= 2'd0;
      strobe_r    <= 1'b0;
    end else begin
      act_valid_r <= act_valid_nxt;
      step_r      <= step_nxt;
      half_r      <= half_nxt;
      col_r       <= col_nxt;
      rep_cnt_r   <= rep_cnt_nxt;
      strobe_r    <= strobe_nxt;
    end
    big_r      <= big_nxt;
    font_idx_r <= font_idx_nxt;
    start_r    <= start_nxt;
    page_r     <= page_nxt;
    rep_r      <= rep_nxt;
    byte_r     <= byte_nxt;
    cmd_r      <= cmd_nxt;
    first_r    <= first_nxt;
    last_r     <= last_nxt;
  end

  assign out_strobe          = strobe_r;
  assign out_byte            = byte_r;
  assign out_is_command      = cmd_r;
  assign out_starts_transfer = first_r;
  assign out_last            = last_r;

endmodule

[rtl/glyph_column_stream_generator.sv]
// Glyph column stream generator: turns print requests into the byte stream for a
// page-addressed display controller.
// Request channel: drive the in_ fields with start high; the word is taken at a
// clock edge where busy is low. One request can wait in the input register while
// the previous one streams, so requests issued ahead keep the output gapless.
// Result channel: one word per cycle on out_byte/out_is_command/
// out_starts_transfer/out_last, marked by out_strobe; out_last flags the final
// word of a request. The receiver has no back-pressure and must take every word.
// With the output side idle, an accepted request passes the input register and
// the sequencer state register before its first word is on the output. One word
// per cycle comes from the byte sequencer: 3 command + 6 data words for a small
// glyph, 3 + 6*repeat per page half for a big digit. cfg_wr_en/cfg_wr_data set
// the big-digit repeat; write it only while no request is in flight.
// Reset (rst_n low at a clock edge) drops any pending and streaming request,
// clears out_strobe and sets the repeat to 3.
module glyph_column_stream_generator (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic       in_func,
  input  logic [4:0] in_glyph,
  input  logic [9:0] in_number,
  input  logic [1:0] in_digit_pos,
  input  logic [6:0] in_col,
  input  logic [3:0] in_page,
  input  logic       cfg_wr_en,
  input  logic [2:0] cfg_wr_data,
  output logic       out_strobe,
  output logic [7:0] out_byte,
  output logic       out_is_command,
  output logic       out_starts_transfer,
  output logic       out_last
);
  import gcsg_pkg::*;
  `include "glyph_column_stream_generator_defines.svh"

  logic [2:0] rep_r;
  logic       take;
  logic       pend_valid;
  gcsg_item_t pend;
  logic       run_open;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rep_r <= REP_RESET;
    end else if (cfg_wr_en) begin
      rep_r <= cfg_wr_data;
    end
  end

  gcsg_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_func      (in_func),
    .in_glyph     (in_glyph),
    .in_number    (in_number),
    .in_digit_pos (in_digit_pos),
    .in_col       (in_col),
    .in_page      (in_page),
    .rep_cfg      (rep_r),
    .take         (take),
    .busy         (busy),
    .pend_valid   (pend_valid),
    .pend         (pend)
  );

  gcsg_seq u_seq (
    .clk                 (clk),
    .rst_n               (rst_n),
    .pend_valid          (pend_valid),
    .pend                (pend),
    .take                (take),
    .out_strobe          (out_strobe),
    .out_byte            (out_byte),
    .out_is_command      (out_is_command),
    .out_starts_transfer (out_starts_transfer),
    .out_last            (out_last)
  );

  // first word of a cursor run
  assign run_open = out_strobe && out_is_command && out_starts_transfer;

  // a cursor run is three command words back to back
  `GCSG_ASSERT_NXT(a_cursor_run, run_open, out_strobe && out_is_command, "cursor run broken")
  // after the final word the next word, if any, opens a new cursor run
  `GCSG_ASSERT_NXT(a_after_last, out_strobe && out_last, !out_strobe || run_open, "no cursor after last")
  // the stream only pauses between requests
  `GCSG_ASSERT_NXT(a_gap_only_between, !out_strobe, !out_strobe || run_open, "stream resumed mid request")
  // the final word of a request is always display data
  `GCSG_ASSERT_IMP(a_last_is_data, out_strobe && out_last, !out_is_command, "last word is a command")

endmodule
